[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL. Each macro expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RRTT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RRTT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/rrtt_pkg.sv]
package rrtt_pkg;

  // Number of task slots in the table.
  localparam int SlotCount = 256;
  localparam int SlotW     = $clog2(SlotCount);
  // The count of running tasks has to reach SlotCount itself.
  localparam int CountW    = SlotW + 1;
  // Task indices on the ports are eight bits wide.
  localparam int TaskW     = 8;
  // Allocation only looks at slots that an eight bit index can name.
  localparam int ScanLimit = (SlotCount < 256) ? SlotCount : 256;
  localparam int ScanW     = $clog2(ScanLimit);

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_RUN   = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_NONE  = 2'd3
  } rrtt_action_e;

  typedef enum logic [1:0] {
    ST_UNUSED  = 2'd0,
    ST_SLEEP   = 2'd1,
    ST_RUNNING = 2'd2
  } rrtt_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_TICK,
    S_HOLD
  } rrtt_state_e;

  // Access requests from the controller to the slot and run list memories.
  typedef struct packed {
    logic [SlotW-1:0] st_rd_addr;
    logic             st_we;
    logic [SlotW-1:0] st_wr_addr;
    rrtt_status_e     st_wr_data;
    logic [SlotW-1:0] rl_rd_addr;
    logic             rl_we;
    logic [SlotW-1:0] rl_wr_addr;
    logic [TaskW-1:0] rl_wr_data;
  } rrtt_mem_req_t;

endpackage

[hw/rtl/rrtt_if.sv]
interface rrtt_in_if;
  import rrtt_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       action;
  logic [TaskW-1:0] task_id;

  modport source (output valid, output action, output task_id, input ready);
  modport sink   (input valid, input action, input task_id, output ready);
endinterface

interface rrtt_out_if;
  import rrtt_pkg::*;

  logic             valid;
  logic             ready;
  logic [TaskW-1:0] task_index;
  logic             success;
  logic             switched;

  modport source (output valid, output task_index, output success, output switched,
                  input ready);
  modport sink   (input valid, input task_index, input success, input switched,
                  output ready);
endinterface

[hw/rtl/rrtt_store.sv]
module rrtt_store (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rrtt_pkg::rrtt_mem_req_t         req_i,
  output rrtt_pkg::rrtt_status_e          st_rd_data_o,
  output logic [rrtt_pkg::TaskW-1:0]      rl_rd_data_o
);
  import rrtt_pkg::*;

  rrtt_status_e     st_mem [SlotCount];
  logic [TaskW-1:0] rl_mem [SlotCount];

  // A slot that was never written still holds its reset status.
  logic [SlotCount-1:0] st_vld_q;

  rrtt_status_e     st_rdata_q;
  logic             st_vld_rd_q;
  logic             st_zero_q;
  logic [TaskW-1:0] rl_rdata_q;
  logic             rl_zero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_vld_q <= '0;
    end else if (req_i.st_we) begin
      st_vld_q[req_i.st_wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.st_we) begin
      st_mem[req_i.st_wr_addr] <= req_i.st_wr_data;
    end
    st_rdata_q  <= st_mem[req_i.st_rd_addr];
    st_vld_rd_q <= st_vld_q[req_i.st_rd_addr];
    st_zero_q   <= (req_i.st_rd_addr == '0);
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rl_we) begin
      rl_mem[req_i.rl_wr_addr] <= req_i.rl_wr_data;
    end
    rl_rdata_q <= rl_mem[req_i.rl_rd_addr];
    rl_zero_q  <= (req_i.rl_rd_addr == '0);
  end

  assign st_rd_data_o = st_vld_rd_q ? st_rdata_q :
                        (st_zero_q ? ST_RUNNING : ST_UNUSED);

  // Entry 0 of the run list is never written after reset and always names slot 0.
  assign rl_rd_data_o = rl_zero_q ? '0 : rl_rdata_q;

endmodule

[hw/rtl/round_robin_task_table_unit.sv]
// Channel  | Port  | Direction | Payload
// ---------+-------+-----------+-------------------------------------
// command  | in_i  | sink      | action (2 bits), task_id (8 bits)
// result   | out_o | source    | task_index (8 bits), success, switched
//
// A run item or an unknown action goes from acceptance through the hold state into the output
// register. A tick item first passes the tick state for the registered read of the run list.
// An allocate item reads the slot status memory one entry per cycle, up to ScanLimit entries
// when the table is full, and then passes the hold state as well.
// After reset slot 0 is running and is the only entry of the run list; no clearing pass.
// One item is in work at a time; a result held on a stalled output delays only the next
// result, since the next item is accepted while the output register still waits.

`include "assert_macros.svh"

module round_robin_task_table_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  rrtt_in_if.sink    in_i,
  rrtt_out_if.source out_o
);
  import rrtt_pkg::*;

  // Controller state.
  rrtt_state_e state_q, state_d;

  // Number of entries in the run list and the current position in it.
  logic [CountW-1:0] count_q, count_d;
  logic [SlotW-1:0]  pos_q, pos_d;

  // Slot whose status arrives from the memory during an allocation scan.
  logic [ScanW-1:0]  chk_q, chk_d;

  // Result of the item in work, waiting for the output register.
  logic [TaskW-1:0]  pend_idx_q, pend_idx_d;
  logic              pend_ok_q, pend_ok_d;
  logic              pend_sw_q, pend_sw_d;

  // Output register.
  logic              out_valid_q, out_valid_d;
  logic [TaskW-1:0]  out_idx_q, out_idx_d;
  logic              out_ok_q, out_ok_d;
  logic              out_sw_q, out_sw_d;

  rrtt_mem_req_t     mem_req;
  rrtt_status_e      st_rd_data;
  logic [TaskW-1:0]  rl_rd_data;

  logic              in_ready;
  logic              out_free;
  logic [CountW-1:0] pos_inc;

  rrtt_store u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (mem_req),
    .st_rd_data_o (st_rd_data),
    .rl_rd_data_o (rl_rd_data)
  );

  assign in_i.ready       = in_ready;
  assign out_o.valid      = out_valid_q;
  assign out_o.task_index = out_idx_q;
  assign out_o.success    = out_ok_q;
  assign out_o.switched   = out_sw_q;

  // The output register can take a new result when it is empty or being emptied.
  assign out_free = !out_valid_q || out_o.ready;
  assign pos_inc  = {1'b0, pos_q} + 1'b1;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    chk_d       = chk_q;
    pend_idx_d  = pend_idx_q;
    pend_ok_d   = pend_ok_q;
    pend_sw_d   = pend_sw_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_idx_d   = out_idx_q;
    out_ok_d    = out_ok_q;
    out_sw_d    = out_sw_q;
    mem_req     = '0;
    in_ready    = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          pend_idx_d = '0;
          pend_ok_d  = 1'b0;
          pend_sw_d  = 1'b0;
          case (rrtt_action_e'(in_i.action))
            ACT_ALLOC: begin
              // Start the scan at slot 0; its status arrives next cycle.
              mem_req.st_rd_addr = '0;
              chk_d              = '0;
              state_d            = S_SCAN;
            end
            ACT_RUN: begin
              // Unless the list is full, the slot becomes running whatever it was and is appended to the list.
              if ((int'(in_i.task_id) < SlotCount) && (count_q != CountW'(SlotCount))) begin
                mem_req.st_we      = 1'b1;
                mem_req.st_wr_addr = SlotW'(in_i.task_id);
                mem_req.st_wr_data = ST_RUNNING;
                mem_req.rl_we      = 1'b1;
                mem_req.rl_wr_addr = count_q[SlotW-1:0];
                mem_req.rl_wr_data = in_i.task_id;
                count_d            = count_q + 1'b1;
                pend_ok_d          = 1'b1;
              end
              state_d = S_HOLD;
            end
            ACT_TICK: begin
              // Advance with wrap when two or more tasks run, then fetch the task.
              if (count_q >= CountW'(2)) begin
                pos_d     = (pos_inc >= count_q) ? '0 : pos_inc[SlotW-1:0];
                pend_sw_d = 1'b1;
              end
              mem_req.rl_rd_addr = pos_d;
              state_d            = S_TICK;
            end
            default: begin
              state_d = S_HOLD;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (st_rd_data == ST_UNUSED) begin
          // First free slot: claim it as sleeping.
          mem_req.st_we      = 1'b1;
          mem_req.st_wr_addr = SlotW'(chk_q);
          mem_req.st_wr_data = ST_SLEEP;
          pend_idx_d         = TaskW'(chk_q);
          pend_ok_d          = 1'b1;
          state_d            = S_HOLD;
        end else if (chk_q == ScanW'(ScanLimit - 1)) begin
          // Every slot is in use; nothing changes.
          state_d = S_HOLD;
        end else begin
          mem_req.st_rd_addr = SlotW'(chk_q + 1'b1);
          chk_d              = chk_q + 1'b1;
        end
      end

      S_TICK: begin
        pend_idx_d = rl_rd_data;
        pend_ok_d  = 1'b1;
        state_d    = S_HOLD;
      end

      S_HOLD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_idx_d   = pend_idx_q;
          out_ok_d    = pend_ok_q;
          out_sw_d    = pend_sw_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= CountW'(1);
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_d_hold: begin
      chk_q      <= chk_d;
      pend_idx_q <= pend_idx_d;
      pend_ok_q  <= pend_ok_d;
      pend_sw_q  <= pend_sw_d;
      out_idx_q  <= out_idx_d;
      out_ok_q   <= out_ok_d;
      out_sw_q   <= out_sw_d;
    end
  end

  // The run list always holds slot 0 and never more entries than there are slots.
  `RRTT_ASSERT_SAME(a_count_range, 1'b1,
    (count_q >= CountW'(1)) && (count_q <= CountW'(SlotCount)),
    "running task count out of range")

  // The current position always names a filled entry of the run list.
  `RRTT_ASSERT_SAME(a_pos_in_list, 1'b1, {1'b0, pos_q} < count_q,
    "current position beyond the run list")

  // A successful run append grows the list by exactly one entry.
  `RRTT_ASSERT_NEXT(a_run_grows,
    in_i.valid && in_i.ready && (in_i.action == ACT_RUN) && (count_q != CountW'(SlotCount)),
    count_q == CountW'($past(count_q) + 1'b1),
    "run append did not grow the run list")

  // A result is loaded into the output register only from the hold state.
  `RRTT_ASSERT_NEXT(a_load_from_hold, !out_valid_q && (state_q != S_HOLD), !out_valid_q,
    "result appeared without a finished item")

endmodule
